// ===== src/bitbang_serial_exchanger_top_assert.svh =====
// Assertion macros for the bit-bang serial exchanger.
// Each macro takes a label, the clock, the active-low reset, the checked
// expressions and a message.
`ifndef BITBANG_SERIAL_EXCHANGER_TOP_ASSERT_SVH
`define BITBANG_SERIAL_EXCHANGER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define BSE_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define BSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BSE_ASSERT(lbl, clk, rst_n, expr, msg)

`define BSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define BSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/bse_pkg.sv =====
package bse_pkg;

    typedef logic [1:0] t_op;
    localparam t_op OP_TICK  = 2'd0;
    localparam t_op OP_START = 2'd1;
    localparam t_op OP_POP   = 2'd2;

    typedef logic [4:0] t_phase;
    localparam t_phase PH_IDLE      = 5'd0;
    localparam t_phase PH_FIRST     = 5'd1;
    localparam t_phase PH_LAST_BIT  = 5'd16;
    localparam t_phase PH_TERM_A    = 5'd17;
    localparam t_phase PH_TERM_B    = 5'd18;
    localparam t_phase PH_TERM_LAST = 5'd19;

    localparam logic [7:0] PAT_IDLE    = 8'h00;
    localparam logic [7:0] PAT_CLK     = 8'h80;
    localparam logic [7:0] PAT_TERM_LO = 8'h0F;
    localparam logic [7:0] PAT_TERM_HI = 8'h8F;

    // byte handed to the receive store at the end of a frame
    typedef struct packed {
        logic       req;
        logic [7:0] data;
    } t_cap;

    typedef struct packed {
        logic [7:0] pattern;
        logic       busy;
    } t_seq_res;

    function automatic logic [7:0] pattern_of(t_phase ph, logic [7:0] so);
        t_phase     pm1;
        logic [2:0] idx;
        logic       b;
        logic [7:0] pat;
        pm1 = ph - PH_FIRST;
        idx = ~pm1[3:1];
        b   = so[idx];
        if (ph >= PH_FIRST && ph <= PH_LAST_BIT) begin
            pat = ph[0] ? {7'b0, b} : (PAT_CLK | {7'b0, b});
        end else if (ph == PH_TERM_A || ph == PH_TERM_LAST) begin
            pat = PAT_TERM_LO;
        end else if (ph == PH_TERM_B) begin
            pat = PAT_TERM_HI;
        end else begin
            pat = PAT_IDLE;
        end
        return pat;
    endfunction

endpackage

// ===== src/bse_seq.sv =====
`include "bitbang_serial_exchanger_top_assert.svh"

module bse_seq
    import bse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_op        i_op,
    input  logic [7:0] i_tx_byte,
    input  logic       i_rx_pin,
    input  logic       i_allow_zeros,
    output t_seq_res   o_res,
    output t_cap       o_cap
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_shift_out, n_shift_out;
    logic [7:0] r_shift_in, n_shift_in;
    logic       r_frame_valid, n_frame_valid;

    always_comb begin
        n_phase       = r_phase;
        n_shift_out   = r_shift_out;
        n_shift_in    = r_shift_in;
        n_frame_valid = r_frame_valid;
        o_cap.req     = 1'b0;
        if (i_en) begin
            case (i_op)
                OP_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        if (r_phase <= PH_LAST_BIT) begin
                            if (r_phase[0]) begin
                                if (r_phase == PH_FIRST) begin
                                    n_frame_valid = i_rx_pin;
                                end
                            end else begin
                                n_shift_in = {r_shift_in[6:0], i_rx_pin};
                            end
                            // store the frame unless it is invalid or a filtered zero
                            if (r_phase == PH_LAST_BIT) begin
                                o_cap.req = r_frame_valid
                                            && (n_shift_in != 8'h00 || i_allow_zeros);
                            end
                        end
                        n_phase = (r_phase >= PH_TERM_LAST) ? PH_IDLE : r_phase + 5'd1;
                    end
                end
                OP_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_shift_out   = i_tx_byte;
                        n_shift_in    = 8'h00;
                        n_frame_valid = 1'b0;
                        n_phase       = PH_FIRST;
                    end
                end
                default: begin
                end
            endcase
        end
        o_cap.data    = n_shift_in;
        o_res.pattern = pattern_of(n_phase, n_shift_out);
        o_res.busy    = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_shift_out   <= 8'h00;
            r_shift_in    <= 8'h00;
            r_frame_valid <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_shift_out   <= n_shift_out;
            r_shift_in    <= n_shift_in;
            r_frame_valid <= n_frame_valid;
        end
    end

    `BSE_ASSERT(a_phase_range, i_clk, i_rst_n, r_phase <= PH_TERM_LAST, "phase out of range")
    `BSE_ASSERT_IMPL(a_cap_at_end, i_clk, i_rst_n, o_cap.req, i_en && r_phase == PH_LAST_BIT && r_frame_valid, "capture outside frame end")

endmodule

// ===== src/bse_fifo.sv =====
`include "bitbang_serial_exchanger_top_assert.svh"

module bse_fifo
    import bse_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cap                     i_cap,
    input  logic                     i_pop,
    output logic                     o_pop_ok,
    output logic [7:0]               o_rd_data,
    output logic [$clog2(DEPTH)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] r_wr_idx, r_rd_idx, r_count;
    logic [7:0]    r_rd_data;
    logic          w_wr;

    // keep one slot free, as the ring indices would otherwise wrap onto each other
    assign w_wr     = i_cap.req && (r_count < AW'(DEPTH - 1));
    assign o_pop_ok = i_pop && (r_count != '0);
    assign o_count  = w_wr ? r_count + 1'b1 : (o_pop_ok ? r_count - 1'b1 : r_count);
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_idx <= (r_wr_idx == AW'(DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
            end
            if (o_pop_ok) begin
                r_rd_idx <= (r_rd_idx == AW'(DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
            end
            r_count <= o_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[r_wr_idx] <= i_cap.data;
        end
        if (o_pop_ok) begin
            r_rd_data <= mem[r_rd_idx];
        end
    end

    `BSE_ASSERT(a_one_side, i_clk, i_rst_n, !(w_wr && o_pop_ok), "write and pop in one item")
    `BSE_ASSERT(a_count_idx, i_clk, i_rst_n, (r_wr_idx >= r_rd_idx) ? (r_count == r_wr_idx - r_rd_idx) : ({1'b0, r_count} == {1'b0, r_wr_idx} + (AW + 1)'(DEPTH) - {1'b0, r_rd_idx}), "count disagrees with indices")

endmodule

// ===== src/bitbang_serial_exchanger_top.sv =====
// Bit-bang serial exchanger: an SPI mode 0 style master, MSB first, that
// drives an 8-bit pin pattern one phase per tick item, with a receive store.
// Input channel i_s_axis_*: tuser carries the op (tick with rx sample, start
// exchange, pop captured byte); tdata carries the byte to send and the rx pin
// level. Every accepted item yields exactly one result item on o_m_axis_*:
// the pattern to hold, busy, the popped byte with its valid flag, and the
// number of bytes held.
// Results are registered through the middle stage and the result register;
// an item is accepted in every cycle while results are taken, since the
// sequencer and store update in one pass and two register stages follow.
// The pop reads the store through one registered memory port.
// The allow-zeros register is written through i_cfg_we/i_cfg_wdata; the
// user writes it only while idle, as the block itself does not enforce it.
// Reset (synchronous, active low) empties both stages, returns the sequencer
// to idle, clears the store indices and the allow-zeros register.
// When the receiver stalls the result register holds, the middle stage fills,
// and then o_s_axis_tready drops until a result is taken.
`include "bitbang_serial_exchanger_top_assert.svh"

module bitbang_serial_exchanger_top
    import bse_pkg::*;
#(
    parameter int BUF_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // tx_byte[7:0], rx_pin[8], zero pad
    input  logic [1:0]  i_s_axis_tuser,  // op[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pin_pattern[7:0], busy_res[8], rx_byte[16:9], rx_valid[17],
    // captured_count[25:18], zero pad
    output logic [31:0] o_m_axis_tdata
);

    localparam int CW = $clog2(BUF_DEPTH);

    logic          r_allow_zeros;
    logic          w_accept, w_s1_move;
    t_seq_res      w_res;
    t_cap          w_cap;
    logic          w_pop_ok;
    logic [7:0]    w_rd_data;
    logic [CW-1:0] w_count;
    logic [CW+7:0] w_count_ext;

    logic          r_s1_valid;
    t_seq_res      r_s1_res;
    logic          r_s1_rvalid;
    logic [7:0]    r_s1_count;

    logic          r_out_valid;
    logic [31:0]   r_out_data;

    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_s1_move       = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || w_s1_move;
    assign w_count_ext     = {8'h00, w_count};

    bse_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_accept),
        .i_op          (i_s_axis_tuser),
        .i_tx_byte     (i_s_axis_tdata[7:0]),
        .i_rx_pin      (i_s_axis_tdata[8]),
        .i_allow_zeros (r_allow_zeros),
        .o_res         (w_res),
        .o_cap         (w_cap)
    );

    bse_fifo #(
        .DEPTH (BUF_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cap     (w_cap),
        .i_pop     (w_accept && i_s_axis_tuser == OP_POP),
        .o_pop_ok  (w_pop_ok),
        .o_rd_data (w_rd_data),
        .o_count   (w_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_zeros <= 1'b0;
        end else if (i_cfg_we) begin
            r_allow_zeros <= i_cfg_wdata;
        end
    end

    // middle stage: pairs with the registered store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept || (r_s1_valid && !w_s1_move);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_res    <= w_res;
            r_s1_rvalid <= w_pop_ok;
            r_s1_count  <= w_count_ext[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_out_data <= {6'b0, r_s1_count, r_s1_rvalid,
                           r_s1_rvalid ? w_rd_data : 8'h00,
                           r_s1_res.busy, r_s1_res.pattern};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `BSE_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !o_s_axis_tready, r_s1_valid && r_out_valid && !i_m_axis_tready, "input stalled with room")
    `BSE_ASSERT_NEXT(a_s1_drains, i_clk, i_rst_n, r_s1_valid && i_m_axis_tready && !w_accept, !r_s1_valid || r_out_valid, "middle stage lost")

endmodule

// ===== tb/sv/bitbang_serial_exchanger_top_test.sv =====
module bitbang_serial_exchanger_top_test;
    import bse_pkg::*;

    localparam t_op OP_UNUSED  = 2'd3;
    localparam int  HOLD_CYCLES = 400;
    localparam int  STALL_LIMIT = 3000;

    // one result item as it sits in tdata[25:0]
    typedef struct packed {
        logic [7:0] held;
        logic       valid;
        logic [7:0] rbyte;
        logic       busy;
        logic [7:0] pattern;
    } exchange_result_t;

    class exchange_scoreboard;
        logic             allow_zeros;
        logic [7:0]       tx_shift;
        logic [7:0]       rx_shift;
        logic             frame_ok;
        t_phase           phase;
        logic [7:0]       rx_store [256];
        logic [7:0]       wr_ptr;
        logic [7:0]       rd_ptr;
        exchange_result_t pending_results [$];
        int               mismatches;

        function new();
            allow_zeros = 1'b0;
            tx_shift    = '0;
            rx_shift    = '0;
            frame_ok    = 1'b0;
            phase       = PH_IDLE;
            wr_ptr      = '0;
            rd_ptr      = '0;
            mismatches  = 0;
        endfunction

        function logic [7:0] phase_pattern();
            logic [2:0] bit_idx;
            logic [4:0] offset;
            logic       b;
            offset  = phase - PH_FIRST;
            bit_idx = 3'd7 - offset[3:1];
            b       = tx_shift[bit_idx];
            if (phase >= PH_FIRST && phase <= PH_LAST_BIT) begin
                return phase[0] ? {7'b0, b} : (PAT_CLK | {7'b0, b});
            end
            case (phase)
                PH_TERM_A, PH_TERM_LAST: return PAT_TERM_LO;
                PH_TERM_B:               return PAT_TERM_HI;
                default:                 return PAT_IDLE;
            endcase
        endfunction

        // work out the result of one accepted input item
        function void note_item(t_op op, logic [7:0] tx, logic rx);
            exchange_result_t r;
            logic [7:0]       held;
            r = '0;
            case (op)
                OP_TICK: begin
                    if (phase != PH_IDLE) begin
                        if (phase <= PH_LAST_BIT) begin
                            if (phase[0]) begin
                                if (phase == PH_FIRST) frame_ok = rx;
                            end else begin
                                rx_shift = {rx_shift[6:0], rx};
                            end
                            if (phase == PH_LAST_BIT) begin
                                held = wr_ptr - rd_ptr;
                                // keep one slot free; drop bytes beyond that
                                if (frame_ok && (rx_shift != 8'h00 || allow_zeros) &&
                                    held != 8'hFF) begin
                                    rx_store[wr_ptr] = rx_shift;
                                    wr_ptr = wr_ptr + 8'd1;
                                end
                            end
                        end
                        phase = (phase >= PH_TERM_LAST) ? PH_IDLE : phase + 5'd1;
                    end
                end
                OP_START: begin
                    if (phase == PH_IDLE) begin
                        tx_shift = tx;
                        rx_shift = '0;
                        frame_ok = 1'b0;
                        phase    = PH_FIRST;
                    end
                end
                OP_POP: begin
                    if (wr_ptr != rd_ptr) begin
                        r.rbyte = rx_store[rd_ptr];
                        r.valid = 1'b1;
                        rd_ptr  = rd_ptr + 8'd1;
                    end
                end
                default: ;
            endcase
            r.pattern = phase_pattern();
            r.busy    = (phase != PH_IDLE);
            r.held    = wr_ptr - rd_ptr;
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [31:0] data);
            exchange_result_t want;
            exchange_result_t got;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result item %h", data);
                return;
            end
            want = pending_results.pop_front();
            got  = data[25:0];
            if (got !== want || data[31:26] !== 6'b0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("result mismatch at %0t (expected/actual): pattern %h/%h",
                           $time, want.pattern, got.pattern);
                    $display(" busy %b/%b byte %h/%h valid %b/%b held %0d/%0d pad %h",
                             want.busy, got.busy, want.rbyte, got.rbyte,
                             want.valid, got.valid, want.held, got.held, data[31:26]);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;  // tx_byte[7:0], rx_pin[8], zero pad
    logic [1:0]  i_s_axis_tuser;  // op[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // pin_pattern[7:0], busy_res[8], rx_byte[16:9], rx_valid[17],
    // captured_count[25:18], zero pad
    logic [31:0] o_m_axis_tdata;

    exchange_scoreboard exchange_sb = new();

    bit sender_idling = 1'b1;
    bit sink_idling   = 1'b1;
    bit hold_results  = 1'b0;
    int items_sent    = 0;
    int stall_cycles  = 0;

    bitbang_serial_exchanger_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // note accepted items on both sides and count cycles with no progress
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            exchange_sb.note_item(t_op'(i_s_axis_tuser), i_s_axis_tdata[7:0],
                                  i_s_axis_tdata[8]);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            exchange_sb.check_result(o_m_axis_tdata);
        end
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial begin : result_sink
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                // long hold-off: let the block fill and stall its input
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results = 1'b0;
            end else if (sink_idling && $urandom_range(0, 9) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // called at a rising edge; returns at the edge that accepts the item
    task automatic send_item(t_op op, logic [7:0] tx, logic rx);
        if (sender_idling && $urandom_range(0, 9) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'b0, rx, tx};
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (exchange_sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_allow_zeros(logic value);
        wait_for_drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        exchange_sb.allow_zeros = value;
    endtask

    // start plus 19 ticks; rx follows the frame flag and byte, noise
    // optionally slips stray items in while busy
    task automatic run_exchange(logic [7:0] tx, logic frame, logic [7:0] rx_byte,
                                bit noise);
        int   ph;
        logic rx;
        send_item(OP_START, tx, 1'($urandom_range(0, 1)));
        for (ph = 1; ph <= 19; ph++) begin
            if (noise && $urandom_range(0, 15) == 0) begin
                send_item(t_op'($urandom_range(1, 3)), 8'($urandom), 1'($urandom_range(0, 1)));
            end
            if (ph == 1) begin
                rx = frame;
            end else if (ph <= 16 && ph % 2 == 0) begin
                rx = rx_byte[7 - (ph - 2) / 2];
            end else begin
                rx = 1'($urandom_range(0, 1));
            end
            send_item(OP_TICK, 8'($urandom), rx);
        end
    endtask

    task automatic random_traffic(int n_items);
        int         stop_at;
        int         pick;
        logic [7:0] rx_byte;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                rx_byte = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
                run_exchange(8'($urandom), 1'($urandom_range(0, 9) != 0), rx_byte, 1'b1);
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(OP_POP, 8'($urandom), 1'($urandom_range(0, 1)));
                end
            end else if (pick < 92) begin
                send_item(t_op'($urandom_range(0, 3)), 8'($urandom),
                          1'($urandom_range(0, 1)));
            end else begin
                // broken sequence: stop somewhere mid-frame
                send_item(OP_START, 8'($urandom), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 18)) begin
                    send_item(OP_TICK, 8'($urandom), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin : stimulus
        int ph;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_TICK;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_allow_zeros(1'b0);

        // idle tick, pop when empty, unused op while idle
        send_item(OP_TICK, 8'hFF, 1'b1);
        send_item(OP_POP, 8'h00, 1'b1);
        send_item(OP_UNUSED, 8'h00, 1'b0);
        // exchange with start, pop and unused op slipped in while busy
        send_item(OP_START, 8'hA5, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b1);
        send_item(OP_START, 8'h00, 1'b0);
        send_item(OP_POP, 8'hFF, 1'b0);
        send_item(OP_UNUSED, 8'hFF, 1'b1);
        for (ph = 2; ph <= 19; ph++) begin
            send_item(OP_TICK, 8'h5A, (ph <= 16) ? 1'b1 : 1'b0);
        end
        send_item(OP_POP, 8'h00, 1'b0);

        random_traffic(300);
        write_allow_zeros(1'b1);
        hold_results = 1'b1;
        random_traffic(300);

        write_allow_zeros(1'b0);
        sender_idling = 1'b0;
        sink_idling   = 1'b0;
        random_traffic(300);

        wait_for_drain();
        repeat (10) @(posedge i_clk);
        if (exchange_sb.mismatches == 0 && exchange_sb.pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== bitbang_serial_exchanger_top.f =====
+incdir+src
src/bse_pkg.sv
src/bse_seq.sv
src/bse_fifo.sv
src/bitbang_serial_exchanger_top.sv
tb/sv/bitbang_serial_exchanger_top_test.sv
